[hdl/rgbls_pkg.sv]
`default_nettype none

package rgbls_pkg;

   // strip geometry
   localparam int MAX_PIXELS     = 256;
   localparam int ROW_AW         = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int PCOUNT_W       = 9;
   localparam int CNT_W          = ($clog2(MAX_PIXELS + 1) > PCOUNT_W) ?
                                   $clog2(MAX_PIXELS + 1) : PCOUNT_W;
   localparam int ROW_W          = 24;
   localparam int BIT_CNT_W      = 5;

   // channel widths
   localparam int REQ_DATA_W     = 32;
   localparam int RSP_DATA_W     = 8;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 16;

   // command codes carried in req_tuser
   typedef enum logic [1:0] {
      FUNC_TICK  = 2'd0,
      FUNC_SET   = 2'd1,
      FUNC_SHOW  = 2'd2,
      FUNC_CLEAR = 2'd3
   } func_type;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_PIXEL_COUNT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_BRIGHTNESS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_HIGH    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_HIGH   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_TICKS   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_RESET_TICKS = 3'd5;

endpackage

`default_nettype wire

[hdl/rgbls_ram.sv]
`default_nettype none

// simple dual-port RAM, registered read, old data on a same-address collision
module rgbls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/rgb_led_strip_serializer.sv]
`default_nettype none

// channel  dir  handshake             payload
// req      in   req_tvalid/tready     tuser: func; tdata: pixel_index, color
// rsp      out  rsp_tvalid/tready     tdata: line_level, busy_res; tlast: frame_done
// csr      in   csr_valid/csr_ready   csr_index, csr_wdata (always ready)
//
// One beat per cycle in unless held off or stalled, one result beat per input beat,
// through an output register. After a set pixel or clear beat taken while idle, a
// one-cycle hold stops intake while prefetched row 0 of the pixel RAM refreshes.
// Pixel bits leave a 24-bit shift register one per bit period; the next row is
// read from the RAM while the current one shifts out.
// Reset is synchronous; the store reads as zero after reset (per-row valid bits).
// Stalls on rsp hold the result and stop intake; bit timing counts beats only.

module rgb_led_strip_serializer (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   // [31:8] color, [7:0] pixel_index
   input  wire logic [rgbls_pkg::REQ_DATA_W-1:0]       req_tdata,
   // [1:0] func
   input  wire logic [1:0]                             req_tuser,
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // [0] line_level, [1] busy_res, [7:2] zero
   output      logic [rgbls_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output      logic                                   rsp_tlast,
   input  wire logic                                   csr_valid,
   output      logic                                   csr_ready,
   input  wire logic [rgbls_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [rgbls_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GAP,
      ST_DATA
   } state_type;

   localparam int AW = rgbls_pkg::ROW_AW;
   localparam int CW = rgbls_pkg::CNT_W;

   // configuration registers
   logic [rgbls_pkg::PCOUNT_W-1:0] pixel_count_ff;
   logic [7:0]                     brightness_ff;
   logic [7:0]                     one_high_ff;
   logic [7:0]                     zero_high_ff;
   logic [7:0]                     bit_ticks_ff;
   logic [15:0]                    reset_ticks_ff;

   // sequencer state
   state_type                      state_ff, state_in;
   logic [15:0]                    tick_ff, tick_in;
   logic [rgbls_pkg::BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [AW-1:0]                  pix_ff, pix_in;
   logic [rgbls_pkg::ROW_W-1:0]    shift_ff, shift_in;
   logic                           hold_ff, hold_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           line_ff, line_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   // row valid bits and RAM ports
   logic [rgbls_pkg::MAX_PIXELS-1:0] valid_ff;
   logic                             rd_valid_ff;
   logic                             ram_we;
   logic                             clear_all;
   logic [AW-1:0]                    ram_waddr;
   logic [rgbls_pkg::ROW_W-1:0]      ram_wdata;
   logic [AW-1:0]                    ram_raddr;
   logic [rgbls_pkg::ROW_W-1:0]      ram_rdata;
   logic [rgbls_pkg::ROW_W-1:0]      row_data;

   // request decode
   logic                   accept;
   rgbls_pkg::func_type    func;
   logic [7:0]             pixel_index;
   logic [23:0]            color;
   logic [CW-1:0]          live;
   logic [16:0]            gap_len;
   logic [16:0]            bit_len;
   logic                   start_gap;
   logic [15:0]            tick_cur;
   logic [7:0]             high_len;
   logic [7:0]             green_s, red_s, blue_s;
   logic [15:0]            green_p, red_p, blue_p;

   assign csr_ready  = 1'b1;
   assign req_tready = !hold_ff && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign func       = rgbls_pkg::func_type'(req_tuser);
   assign pixel_index = req_tdata[7:0];
   assign color      = req_tdata[31:8];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(rgbls_pkg::RSP_DATA_W - 2){1'b0}}, busy_ff, line_ff};
   assign rsp_tlast  = done_ff;

   // pixels actually on the strip, saturated to the store size
   assign live = (CW'(pixel_count_ff) > CW'(rgbls_pkg::MAX_PIXELS)) ?
                 CW'(rgbls_pkg::MAX_PIXELS) : CW'(pixel_count_ff);

   // zero gap or bit length counts as one tick
   assign gap_len = (reset_ticks_ff == 16'd0) ? 17'd1 : {1'b0, reset_ticks_ff};
   assign bit_len = (bit_ticks_ff == 8'd0) ? 17'd1 : {9'd0, bit_ticks_ff};

   // brightness scaling of a new color
   assign green_p = {8'd0, color[15:8]}  * {8'd0, brightness_ff};
   assign red_p   = {8'd0, color[23:16]} * {8'd0, brightness_ff};
   assign blue_p  = {8'd0, color[7:0]}   * {8'd0, brightness_ff};
   assign green_s = (brightness_ff != 8'd0) ? green_p[15:8] : color[15:8];
   assign red_s   = (brightness_ff != 8'd0) ? red_p[15:8]   : color[23:16];
   assign blue_s  = (brightness_ff != 8'd0) ? blue_p[15:8]  : color[7:0];

   // prefetched row, zero if never written since reset or clear
   assign row_data  = rd_valid_ff ? ram_rdata : '0;
   assign ram_raddr = (state_ff == ST_DATA) ? AW'(pix_ff + AW'(1)) : '0;
   assign ram_waddr = AW'(pixel_index);
   assign ram_wdata = {green_s, red_s, blue_s};

   assign high_len  = shift_ff[rgbls_pkg::ROW_W-1] ? one_high_ff : zero_high_ff;

   // command decode and tick sequencer
   always_comb begin
      state_in     = state_ff;
      tick_in      = tick_ff;
      bit_cnt_in   = bit_cnt_ff;
      pix_in       = pix_ff;
      shift_in     = shift_ff;
      hold_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      line_in      = line_ff;
      busy_in      = busy_ff;
      done_in      = done_ff;
      ram_we       = 1'b0;
      clear_all    = 1'b0;
      start_gap    = 1'b0;
      tick_cur     = tick_ff;

      if (accept) begin
         rsp_valid_in = 1'b1;
         line_in      = 1'b0;
         busy_in      = 1'b0;
         done_in      = 1'b0;

         if (state_ff == ST_IDLE) begin
            unique case (func)
               rgbls_pkg::FUNC_SET: begin
                  ram_we  = (CW'(pixel_index) < live);
                  hold_in = 1'b1;
               end
               rgbls_pkg::FUNC_CLEAR: begin
                  clear_all = 1'b1;
                  hold_in   = 1'b1;
               end
               rgbls_pkg::FUNC_SHOW: begin
                  start_gap = 1'b1;
                  tick_cur  = 16'd0;
               end
               rgbls_pkg::FUNC_TICK: begin
               end
               default: begin
               end
            endcase
         end

         if (state_ff == ST_GAP || start_gap) begin
            busy_in = 1'b1;
            if ({1'b0, tick_cur} + 17'd1 >= gap_len) begin
               tick_in    = 16'd0;
               bit_cnt_in = '0;
               pix_in     = '0;
               shift_in   = row_data;
               if (live == '0) begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DATA;
               end
            end else begin
               tick_in  = tick_cur + 16'd1;
               state_in = ST_GAP;
            end
         end else if (state_ff == ST_DATA) begin
            busy_in = 1'b1;
            line_in = (tick_ff < {8'd0, high_len});
            if ({1'b0, tick_ff} + 17'd1 >= bit_len) begin
               tick_in = 16'd0;
               if (bit_cnt_ff == rgbls_pkg::BIT_CNT_W'(rgbls_pkg::ROW_W - 1)) begin
                  // pixel finished: take the prefetched row
                  bit_cnt_in = '0;
                  shift_in   = row_data;
                  pix_in     = AW'(pix_ff + AW'(1));
                  if (CW'(pix_ff) + CW'(1) >= live) begin
                     done_in  = 1'b1;
                     state_in = ST_IDLE;
                     pix_in   = '0;
                  end
               end else begin
                  bit_cnt_in = bit_cnt_ff + rgbls_pkg::BIT_CNT_W'(1);
                  shift_in   = {shift_ff[rgbls_pkg::ROW_W-2:0], 1'b0};
               end
            end else begin
               tick_in = tick_ff + 16'd1;
            end
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tick_ff      <= 16'd0;
         bit_cnt_ff   <= '0;
         pix_ff       <= '0;
         hold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         bit_cnt_ff   <= bit_cnt_in;
         pix_ff       <= pix_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      shift_ff <= shift_in;
      line_ff  <= line_in;
      busy_ff  <= busy_in;
      done_ff  <= done_in;
   end

   // row valid bits: cleared by reset and clear, set by a store
   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         valid_ff <= '0;
      end else if (ram_we) begin
         valid_ff[ram_waddr] <= 1'b1;
      end
      rd_valid_ff <= valid_ff[ram_raddr];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_count_ff <= 9'd64;
         brightness_ff  <= 8'd0;
         one_high_ff    <= 8'd13;
         zero_high_ff   <= 8'd7;
         bit_ticks_ff   <= 8'd20;
         reset_ticks_ff <= 16'd800;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rgbls_pkg::REG_PIXEL_COUNT: pixel_count_ff <= csr_wdata[8:0];
            rgbls_pkg::REG_BRIGHTNESS:  brightness_ff  <= csr_wdata[7:0];
            rgbls_pkg::REG_ONE_HIGH:    one_high_ff    <= csr_wdata[7:0];
            rgbls_pkg::REG_ZERO_HIGH:   zero_high_ff   <= csr_wdata[7:0];
            rgbls_pkg::REG_BIT_TICKS:   bit_ticks_ff   <= csr_wdata[7:0];
            rgbls_pkg::REG_RESET_TICKS: reset_ticks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // pixel store, one row of green, red, blue per pixel
   rgbls_ram #(
      .WIDTH (rgbls_pkg::ROW_W),
      .DEPTH (rgbls_pkg::MAX_PIXELS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

endmodule

`default_nettype wire

[hdl/rgbls_checker.sv]
`default_nettype none

module rgbls_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [rgbls_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input wire logic                                rsp_tlast
);

   // no result beat right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   // frame end only while busy
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tdata[1])
      else $error("frame end outside a frame");

   // line high only while sending
   a_line_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> rsp_tdata[1])
      else $error("line high while idle");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result beat changed");

endmodule

bind rgb_led_strip_serializer rgbls_checker u_rgbls_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
